/* design/cartridge_bank_mapper_macros.svh */
// Assertion macros shared by the verification files of the cartridge bank mapper.
// Depends on nothing; included by the port checker.
`ifndef CARTRIDGE_BANK_MAPPER_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_MACROS_SVH

// Implication checked in the same cycle, disabled while reset is asserted.
`define CBM_ASSERT_NOW(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("cartridge bank mapper check failed");

// Implication checked in the next cycle, disabled while reset is asserted.
`define CBM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("cartridge bank mapper check failed");

`endif

/* design/cbm_pkg.sv */
// Package of the cartridge bank mapper: codes, constants, structs and helper functions.
// Used by every module of the block; depends on nothing.
`default_nettype none

package cbm_pkg;

	localparam int unsigned ROM_ADDR_BITS_DEF = 21;
	localparam int unsigned RAM_ADDR_BITS_DEF = 16;
	localparam int unsigned MAPPED_W          = 21;
	localparam int unsigned BUS_ADDR_W        = 16;
	localparam int unsigned BYTE_W            = 8;
	localparam int unsigned CLOCK_REGS        = 5;
	localparam int unsigned S_TDATA_W         = 24;
	localparam int unsigned M_TDATA_W         = 40;
	localparam int unsigned TARGET_W          = 3;
	localparam int unsigned APB_ADDR_W        = 3;
	localparam int unsigned APB_DATA_W        = 32;

	localparam logic [BUS_ADDR_W-1:0] BOOT_OFF_ADDR = 16'hFF50;
	localparam logic [8:0]            TWO_RAM_MASK  = 9'h1FF;
	localparam logic [3:0]            GATE_KEY      = 4'hA;
	localparam logic [7:0]            CLOCK_SEL_MAX = 8'h0C;
	localparam logic [7:0]            OPEN_BUS_BYTE = 8'hFF;

	typedef enum logic [1:0] {
		MAP_NONE  = 2'd0,
		MAP_ONE   = 2'd1,
		MAP_TWO   = 2'd2,
		MAP_THREE = 2'd3
	} mapper_kind_t;

	typedef enum logic [TARGET_W-1:0] {
		TGT_INTERNAL = 3'd0,
		TGT_BOOT_ROM = 3'd1,
		TGT_CART_ROM = 3'd2,
		TGT_CART_RAM = 3'd3,
		TGT_CLOCK    = 3'd4,
		TGT_OPEN_BUS = 3'd5,
		TGT_DROPPED  = 3'd6
	} target_t;

	typedef enum logic {
		ACT_READ  = 1'b0,
		ACT_WRITE = 1'b1
	} action_t;

	typedef enum logic {
		REG_MAPPER_KIND  = 1'b0,
		REG_CART_HAS_RAM = 1'b1
	} reg_index_t;

	typedef struct packed {
		mapper_kind_t mapper_kind;
		logic         cart_has_ram;
	} cbm_cfg_t;

	typedef struct packed {
		action_t               action;
		logic [BUS_ADDR_W-1:0] bus_address;
		logic [BYTE_W-1:0]     bus_data;
	} cbm_item_t;

	typedef struct packed {
		target_t             target;
		logic [MAPPED_W-1:0] mapped_address;
		logic [BYTE_W-1:0]   direct_data;
		logic                store_strobe;
		logic [BYTE_W-1:0]   store_byte;
		logic                set_high_nibble;
	} cbm_result_t;

	typedef struct packed {
		logic [6:0]                         rom_bank_low;
		logic [1:0]                         upper_bank_bits;
		logic                               banking_mode;
		logic                               ram_gate;
		logic [7:0]                         ram_bank_select;
		logic [7:0]                         latch_last;
		logic [CLOCK_REGS-1:0][BYTE_W-1:0]  clock_live;
		logic [CLOCK_REGS-1:0][BYTE_W-1:0]  clock_latched;
		logic                               boot_done;
	} cbm_state_t;

	function automatic logic [BYTE_W-1:0] clock_mask(input logic [2:0] k);
		logic [BYTE_W-1:0] m;
		case (k)
			3'd0: m = 8'h3F;
			3'd1: m = 8'h3F;
			3'd2: m = 8'h1F;
			3'd3: m = 8'hFF;
			3'd4: m = 8'hC1;
			default: m = 8'h00;
		endcase
		return m;
	endfunction

	function automatic logic gate_value(input logic [BYTE_W-1:0] d);
		return d[3:0] == GATE_KEY;
	endfunction

	function automatic logic [6:0] nonzero_bank(input logic [6:0] v);
		return (v == 7'd0) ? 7'd1 : v;
	endfunction

endpackage

`default_nettype wire

/* design/cbm_cfg.sv */
// APB register file of the cartridge bank mapper: mapper kind and cartridge RAM flag.
// Depends on cbm_pkg.
`default_nettype none

module cbm_cfg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [cbm_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [cbm_pkg::APB_DATA_W-1:0]    pwdata,
	output logic      [cbm_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                   pready,
	output cbm_pkg::cbm_cfg_t                      cfg
);
	import cbm_pkg::*;

	cbm_cfg_t   cfg_q;
	reg_index_t reg_idx;
	logic       wr_en;

	assign reg_idx = reg_index_t'(paddr[2]);
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mapper_kind  <= MAP_NONE;
			cfg_q.cart_has_ram <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MAPPER_KIND:  cfg_q.mapper_kind  <= mapper_kind_t'(pwdata[1:0]);
				REG_CART_HAS_RAM: cfg_q.cart_has_ram <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MAPPER_KIND:  prdata = {30'd0, cfg_q.mapper_kind};
			REG_CART_HAS_RAM: prdata = {31'd0, cfg_q.cart_has_ram};
			default:          prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* design/cbm_decode.sv */
// Access decode of the cartridge bank mapper: result of one bus access and the next banking state.
// Purely combinational; depends on cbm_pkg.
`default_nettype none

module cbm_decode #(
	parameter int unsigned ROM_ADDR_BITS = cbm_pkg::ROM_ADDR_BITS_DEF,
	parameter int unsigned RAM_ADDR_BITS = cbm_pkg::RAM_ADDR_BITS_DEF
) (
	input  cbm_pkg::cbm_item_t   item,
	input  cbm_pkg::cbm_cfg_t    cfg,
	input  cbm_pkg::cbm_state_t  state,
	output cbm_pkg::cbm_result_t result,
	output cbm_pkg::cbm_state_t  state_nxt
);
	import cbm_pkg::*;

	localparam logic [MAPPED_W-1:0] ROM_MASK = (ROM_ADDR_BITS >= MAPPED_W) ?
		{MAPPED_W{1'b1}} : MAPPED_W'((64'd1 << ROM_ADDR_BITS) - 64'd1);
	localparam logic [MAPPED_W-1:0] RAM_MASK = (RAM_ADDR_BITS >= MAPPED_W) ?
		{MAPPED_W{1'b1}} : MAPPED_W'((64'd1 << RAM_ADDR_BITS) - 64'd1);

	function automatic logic [MAPPED_W-1:0] rom_at(input logic [6:0] b, input logic [13:0] o);
		return {b, o} & ROM_MASK;
	endfunction

	function automatic logic [MAPPED_W-1:0] ram_at(input logic [7:0] b, input logic [12:0] o);
		return {b, o} & RAM_MASK;
	endfunction

	logic [BUS_ADDR_W-1:0] a;
	logic [BYTE_W-1:0]     d;
	logic                  ram_area;
	logic                  sel_ram;
	logic                  sel_clock;
	logic [2:0]            clk_idx;
	logic [7:0]            ram_bank;
	logic [6:0]            hi_bank;

	assign a         = item.bus_address;
	assign d         = item.bus_data;
	assign ram_area  = a[15:13] == 3'b101;
	assign sel_ram   = state.ram_bank_select[7:3] == 5'd0;
	assign sel_clock = state.ram_bank_select <= CLOCK_SEL_MAX;
	assign clk_idx   = state.ram_bank_select[2:0];
	assign ram_bank  = state.banking_mode ? {6'd0, state.upper_bank_bits} : 8'd0;

	always_comb begin
		case (cfg.mapper_kind)
			MAP_ONE: hi_bank = {state.upper_bank_bits, state.rom_bank_low[4:0]};
			MAP_TWO: hi_bank = {3'd0, state.rom_bank_low[3:0]};
			default: hi_bank = state.rom_bank_low;
		endcase
	end

	always_comb begin
		result    = '{target: TGT_DROPPED, default: '0};
		state_nxt = state;
		if (item.action == ACT_READ) begin
			if (!state.boot_done && a[15:8] == 8'd0) begin
				result.target         = TGT_BOOT_ROM;
				result.mapped_address = {5'd0, a};
			end else if (cfg.mapper_kind == MAP_NONE) begin
				if (!a[15]) begin
					result.target         = TGT_CART_ROM;
					result.mapped_address = {6'd0, a[14:0]} & ROM_MASK;
				end else begin
					result.target         = TGT_INTERNAL;
					result.mapped_address = {5'd0, a};
				end
			end else if (a[15:14] == 2'b00) begin
				result.target = TGT_CART_ROM;
				if (cfg.mapper_kind == MAP_ONE && state.banking_mode) begin
					result.mapped_address = rom_at({state.upper_bank_bits, 5'd0}, a[13:0]);
				end else begin
					result.mapped_address = rom_at(7'd0, a[13:0]);
				end
			end else if (a[15:14] == 2'b01) begin
				result.target         = TGT_CART_ROM;
				result.mapped_address = rom_at(hi_bank, a[13:0]);
			end else if (ram_area) begin
				result.target      = TGT_OPEN_BUS;
				result.direct_data = OPEN_BUS_BYTE;
				if (state.ram_gate) begin
					if (cfg.mapper_kind == MAP_ONE) begin
						result.target         = TGT_CART_RAM;
						result.direct_data    = '0;
						result.mapped_address = ram_at(ram_bank, a[12:0]);
					end else if (cfg.mapper_kind == MAP_TWO) begin
						result.target          = TGT_CART_RAM;
						result.direct_data     = '0;
						result.set_high_nibble = 1'b1;
						result.mapped_address  = {12'd0, a[8:0] & TWO_RAM_MASK};
					end else if (sel_ram) begin
						if (cfg.cart_has_ram) begin
							result.target         = TGT_CART_RAM;
							result.direct_data    = '0;
							result.mapped_address = ram_at(state.ram_bank_select, a[12:0]);
						end
					end else if (sel_clock) begin
						result.target         = TGT_CLOCK;
						result.mapped_address = {18'd0, clk_idx};
						result.direct_data    = state.clock_latched[clk_idx];
					end
				end
			end else begin
				result.target         = TGT_INTERNAL;
				result.mapped_address = {5'd0, a};
			end
		end else begin
			if (!a[15]) begin
				case (cfg.mapper_kind)
					MAP_ONE: begin
						case (a[14:13])
							2'd0: if (cfg.cart_has_ram) state_nxt.ram_gate = gate_value(d);
							2'd1: state_nxt.rom_bank_low = nonzero_bank({2'd0, d[4:0]});
							2'd2: state_nxt.upper_bank_bits = d[1:0];
							default: state_nxt.banking_mode = d[0];
						endcase
					end
					MAP_TWO: begin
						if (!a[14]) begin
							if (!a[8]) state_nxt.ram_gate = gate_value(d);
							else state_nxt.rom_bank_low = nonzero_bank({3'd0, d[3:0]});
						end
					end
					MAP_THREE: begin
						case (a[14:13])
							2'd0: state_nxt.ram_gate = gate_value(d);
							2'd1: state_nxt.rom_bank_low = nonzero_bank(d[6:0]);
							2'd2: state_nxt.ram_bank_select = d;
							default: begin
								if (state.latch_last == 8'd0 && d == 8'd1) begin
									state_nxt.clock_latched = state.clock_live;
								end
								state_nxt.latch_last = d;
							end
						endcase
					end
					default: ;
				endcase
			end else if (ram_area && cfg.mapper_kind != MAP_NONE) begin
				if (cfg.mapper_kind == MAP_ONE) begin
					if (state.ram_gate && cfg.cart_has_ram) begin
						result.target         = TGT_CART_RAM;
						result.store_strobe   = 1'b1;
						result.store_byte     = d;
						result.mapped_address = ram_at(ram_bank, a[12:0]);
					end
				end else if (cfg.mapper_kind == MAP_TWO) begin
					if (state.ram_gate && cfg.cart_has_ram) begin
						result.target         = TGT_CART_RAM;
						result.store_strobe   = 1'b1;
						result.store_byte     = {4'd0, d[3:0]};
						result.mapped_address = {12'd0, a[8:0] & TWO_RAM_MASK};
					end
				end else if (state.ram_gate) begin
					if (sel_ram) begin
						if (cfg.cart_has_ram) begin
							result.target         = TGT_CART_RAM;
							result.store_strobe   = 1'b1;
							result.store_byte     = d;
							result.mapped_address = ram_at(state.ram_bank_select, a[12:0]);
						end
					end else if (sel_clock) begin
						state_nxt.clock_live[clk_idx] = d & clock_mask(clk_idx);
						result.target         = TGT_CLOCK;
						result.mapped_address = {18'd0, clk_idx};
						result.store_strobe   = 1'b1;
						result.store_byte     = d & clock_mask(clk_idx);
					end
				end
			end else begin
				result.target         = TGT_INTERNAL;
				result.mapped_address = {5'd0, a};
				result.store_strobe   = 1'b1;
				result.store_byte     = d;
				if (a == BOOT_OFF_ADDR && d != 8'd0) state_nxt.boot_done = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* design/cartridge_bank_mapper.sv */
// Top level of the cartridge bank mapper: stream channels, pipeline and banking state registers.
// Depends on cbm_pkg, cbm_cfg and cbm_decode.
//
// Usage:
// The slave stream carries one CPU bus access per transaction: s_tuser is the action
// (read or write), s_tdata holds the address and the data byte. The master stream returns
// one result per access: m_tuser is the target store, m_tdata holds the mapped address,
// the direct read byte, the write strobe, the write byte and the high-nibble flag.
// An access is registered in the input register at the edge that accepts it and decoded against
// the banking state while it is held there; its result is registered in the output register when
// the access advances, which raises m_tvalid.
// One access is accepted in every cycle when the
// receiver keeps m_tready high; the decode stage updates the banking state as each access
// moves into the output register, so accesses see the state in their order of arrival.
// When the receiver stalls, the result holds in the output register, the next access
// waits in the input register, and s_tready falls once both are full.
// Reset clears both pipeline stages, sets ROM bank one, clears all other banking and clock registers,
// restores the boot ROM overlay and selects no mapper without cartridge RAM. The user is to write the
// mapper kind and the cartridge RAM flag over the APB port only while the block is idle; the block does not enforce it.
`default_nettype none

module cartridge_bank_mapper #(
	parameter int unsigned ROM_ADDR_BITS = cbm_pkg::ROM_ADDR_BITS_DEF,
	parameter int unsigned RAM_ADDR_BITS = cbm_pkg::RAM_ADDR_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// bus_address [15:0], bus_data [23:16]
	input  wire logic [cbm_pkg::S_TDATA_W-1:0]    s_tdata,
	// action [0]
	input  wire logic                             s_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// mapped_address [20:0], direct_data [28:21], store_strobe [29],
	// store_byte [37:30], set_high_nibble [38], zero [39]
	output logic      [cbm_pkg::M_TDATA_W-1:0]    m_tdata,
	// target [2:0]
	output logic      [cbm_pkg::TARGET_W-1:0]     m_tuser,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [cbm_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [cbm_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [cbm_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                  pready
);
	import cbm_pkg::*;

	cbm_cfg_t    cfg;
	cbm_item_t   item_s1;
	logic        valid_s1;
	cbm_result_t res_s2;
	logic        valid_s2;
	cbm_result_t res_nxt;
	cbm_state_t  state_q;
	cbm_state_t  state_nxt;
	logic        adv_s1;
	logic        take_in;

	cbm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cbm_decode #(
		.ROM_ADDR_BITS (ROM_ADDR_BITS),
		.RAM_ADDR_BITS (RAM_ADDR_BITS)
	) u_decode (
		.item      (item_s1),
		.cfg       (cfg),
		.state     (state_q),
		.result    (res_nxt),
		.state_nxt (state_nxt)
	);

	assign adv_s1   = valid_s1 & (~valid_s2 | m_tready);
	assign s_tready = ~valid_s1 | adv_s1;
	assign take_in  = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1.action      <= action_t'(s_tuser);
			item_s1.bus_address <= s_tdata[15:0];
			item_s1.bus_data    <= s_tdata[23:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{rom_bank_low: 7'd1, default: '0};
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.target;
	assign m_tdata  = {1'b0, res_s2.set_high_nibble, res_s2.store_byte, res_s2.store_strobe,
		res_s2.direct_data, res_s2.mapped_address};

endmodule

`default_nettype wire

/* design/cbm_checker.sv */
// Port checker of the cartridge bank mapper and its bind to the top level.
// Depends on cbm_pkg and cartridge_bank_mapper_macros.svh.
`default_nettype none
`include "cartridge_bank_mapper_macros.svh"

module cbm_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             m_tvalid,
	input wire logic                             m_tready,
	input wire logic [cbm_pkg::M_TDATA_W-1:0]    m_tdata,
	input wire logic [cbm_pkg::TARGET_W-1:0]     m_tuser,
	input wire logic                             pready
);
	import cbm_pkg::*;

	`CBM_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	`CBM_ASSERT_NOW(a_strobe_target, clk, arst_n, m_tvalid && m_tdata[29],
		m_tuser == TGT_CART_RAM || m_tuser == TGT_CLOCK || m_tuser == TGT_INTERNAL)

	`CBM_ASSERT_NOW(a_open_bus_byte, clk, arst_n, m_tvalid && m_tuser == TGT_OPEN_BUS,
		m_tdata[28:21] == OPEN_BUS_BYTE && m_tdata[20:0] == '0 && !m_tdata[29])

	`CBM_ASSERT_NOW(a_high_nibble, clk, arst_n, m_tvalid && m_tdata[38],
		m_tuser == TGT_CART_RAM && !m_tdata[29])

	`CBM_ASSERT_NOW(a_pready_high, clk, arst_n, 1'b1, pready)

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.pready   (pready)
);

`default_nettype wire
